/* hw/rtl/golay_23_12_decoder_defines.svh */
// Assertion helpers for the decoder.
`ifndef GOLAY_23_12_DECODER_DEFINES_SVH
`define GOLAY_23_12_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GOL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("golay decoder check failed");

// Next-cycle implication, disabled while in reset.
`define GOL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("golay decoder check failed");

`endif

/* hw/rtl/gol_pkg.sv */
`default_nettype none

package gol_pkg;

  localparam int WORD_W = 23;
  localparam int PAR_W  = 11;
  localparam int DATA_W = 12;
  localparam int DIDX_W = 4;   // index into the data bits
  localparam int WIDX_W = 5;   // index into the whole word
  localparam int N_PAIR = 66;  // data bit pairs
  localparam int N_TRIP = 220; // data bit triples

  localparam logic [PAR_W:0] GEN_POLY = 12'hC75;

  typedef logic [PAR_W-1:0]                syn_t;
  typedef logic [WORD_W-1:0][PAR_W-1:0]    syn_tab_t;
  typedef logic [DIDX_W-1:0]               didx_t;

  typedef struct packed {
    didx_t a;
    didx_t b;
  } pair_t;

  typedef struct packed {
    didx_t a;
    didx_t b;
    didx_t c;
  } trip_t;

  typedef pair_t [N_PAIR-1:0] pair_tab_t;
  typedef trip_t [N_TRIP-1:0] trip_tab_t;

  // Remainder of a word divided by the generator polynomial.
  function automatic syn_t poly_rem(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    r = w;
    for (int b = WORD_W - 1; b >= PAR_W; b--) begin
      if (r[b]) begin
        r = r ^ (WORD_W'(GEN_POLY) << (b - PAR_W));
      end
    end
    return r[PAR_W-1:0];
  endfunction

  function automatic syn_tab_t build_syn_tab();
    syn_tab_t t;
    for (int i = 0; i < WORD_W; i++) begin
      t[i] = poly_rem(WORD_W'(1) << i);
    end
    return t;
  endfunction

  function automatic pair_tab_t build_pairs();
    pair_tab_t  t;
    logic [6:0] n;
    n = '0;
    for (int a = 0; a < DATA_W; a++) begin
      for (int b = a + 1; b < DATA_W; b++) begin
        t[n].a = DIDX_W'(a);
        t[n].b = DIDX_W'(b);
        n = n + 7'd1;
      end
    end
    return t;
  endfunction

  function automatic trip_tab_t build_trips();
    trip_tab_t  t;
    logic [7:0] n;
    n = '0;
    for (int a = 0; a < DATA_W; a++) begin
      for (int b = a + 1; b < DATA_W; b++) begin
        for (int c = b + 1; c < DATA_W; c++) begin
          t[n].a = DIDX_W'(a);
          t[n].b = DIDX_W'(b);
          t[n].c = DIDX_W'(c);
          n = n + 8'd1;
        end
      end
    end
    return t;
  endfunction

  localparam syn_tab_t  BIT_SYN = build_syn_tab();
  localparam pair_tab_t PAIRS   = build_pairs();
  localparam trip_tab_t TRIPS   = build_trips();

endpackage

`default_nettype wire

/* hw/rtl/gol_if.sv */
`default_nettype none

interface gol_in_if;
  logic                      valid;
  logic                      ready;
  logic [gol_pkg::WORD_W-1:0] received_word;

  modport source (output valid, output received_word, input ready);
  modport sink   (input valid, input received_word, output ready);
endinterface

interface gol_out_if;
  logic                      valid;
  logic                      ready;
  logic [gol_pkg::DATA_W-1:0] data_bits;

  modport source (output valid, output data_bits, input ready);
  modport sink   (input valid, input data_bits, output ready);
endinterface

`default_nettype wire

/* hw/rtl/golay_23_12_decoder.sv */
// Golay(23,12) decoder.
// word_in carries one 23-bit received word per beat (data in bits 22..11,
// parity in bits 10..0). data_out carries the 12 corrected data bits per beat.
// Any pattern of up to three bit errors is corrected; every word decodes.
// A beat moves when valid and ready are both high at a rising edge of clk.
// Three register stages: syndrome, candidate error match, correction.
// An accepted beat is held in syn1, then the hit registers, then data3.
// Throughput is one word per cycle while data_out does not stall, set by the
// three stages each taking a new word every cycle.
// When data_out stalls, the stages fill up one by one; word_in.ready drops
// only once all three hold a word, and nothing is lost or repeated.
// rst (synchronous, active high) empties all stages; the block holds no
// other state, so words may flow on the first cycle after reset.
`default_nettype none

`include "golay_23_12_decoder_defines.svh"

module golay_23_12_decoder (
  input  wire logic  clk,
  input  wire logic  rst,
  gol_in_if.sink     word_in,
  gol_out_if.source  data_out
);

  import gol_pkg::*;

  function automatic logic [3:0] weight11(input syn_t v);
    logic [2:0] lo;
    logic [2:0] hi;
    lo = '0;
    hi = '0;
    for (int i = 0; i < 6; i++) begin
      lo = lo + 3'(v[i]);
    end
    for (int i = 6; i < PAR_W; i++) begin
      hi = hi + 3'(v[i]);
    end
    return 4'(lo) + 4'(hi);
  endfunction

  function automatic syn_t data_syn(input didx_t d);
    return BIT_SYN[WIDX_W'(PAR_W) + WIDX_W'(d)];
  endfunction

  // Stage 1: syndrome
  logic              v1;
  logic [DATA_W-1:0] data1;
  syn_t              syn1;
  syn_t              syn_next;

  // Stage 2: candidate matches
  logic              v2;
  logic [DATA_W-1:0] data2;
  logic              hit0;
  logic [DATA_W-1:0] hit1;
  logic [N_PAIR-1:0] hit2;
  logic [N_TRIP-1:0] hit3;
  logic              hit0_next;
  logic [DATA_W-1:0] hit1_next;
  logic [N_PAIR-1:0] hit2_next;
  logic [N_TRIP-1:0] hit3_next;

  // Stage 3: output
  logic              v3;
  logic [DATA_W-1:0] data3;
  logic [DATA_W-1:0] err;

  logic r1;
  logic r2;
  logic r3;

  assign r3 = !v3 || data_out.ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;

  assign word_in.ready  = r1;
  assign data_out.valid = v3;
  assign data_out.data_bits = data3;

  always_comb begin
    syn_next = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (word_in.received_word[i]) begin
        syn_next = syn_next ^ BIT_SYN[i];
      end
    end
  end

  // Exactly one candidate matches: the data part of the unique error pattern.
  always_comb begin
    hit0_next = (weight11(syn1) <= 4'd3);
    for (int j = 0; j < DATA_W; j++) begin
      hit1_next[j] = (weight11(syn1 ^ data_syn(DIDX_W'(j))) <= 4'd2);
    end
    for (int p = 0; p < N_PAIR; p++) begin
      hit2_next[p] = (weight11(syn1 ^ data_syn(PAIRS[p].a) ^ data_syn(PAIRS[p].b))
                      <= 4'd1);
    end
    for (int t = 0; t < N_TRIP; t++) begin
      hit3_next[t] = (syn1 == (data_syn(TRIPS[t].a) ^ data_syn(TRIPS[t].b)
                               ^ data_syn(TRIPS[t].c)));
    end
  end

  always_comb begin
    err = hit1;
    for (int p = 0; p < N_PAIR; p++) begin
      if (hit2[p]) begin
        err[PAIRS[p].a] = 1'b1;
        err[PAIRS[p].b] = 1'b1;
      end
    end
    for (int t = 0; t < N_TRIP; t++) begin
      if (hit3[t]) begin
        err[TRIPS[t].a] = 1'b1;
        err[TRIPS[t].b] = 1'b1;
        err[TRIPS[t].c] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= word_in.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (word_in.valid && r1) begin
      data1 <= word_in.received_word[WORD_W-1:PAR_W];
      syn1  <= syn_next;
    end
    if (v1 && r2) begin
      data2 <= data1;
      hit0  <= hit0_next;
      hit1  <= hit1_next;
      hit2  <= hit2_next;
      hit3  <= hit3_next;
    end
    // flip the data bits that the matched pattern names
    if (v2 && r3) begin
      data3 <= data2 ^ err;
    end
  end

  `GOL_ASSERT_NEXT(a_one_match, clk, rst, v1 && r2, $onehot({hit0, hit1, hit2, hit3}))
  `GOL_ASSERT_NEXT(a_clean_pass, clk, rst, v2 && r3 && hit0, data3 == $past(data2))
  `GOL_ASSERT_NOW(a_full_stall, clk, rst, !word_in.ready, v1 && v2 && v3 && !data_out.ready)

endmodule

`default_nettype wire
